/* hw/rtl/ctgr_pkg.sv */
// ----------------------------------------------------------------------------
// Colour temperature gamma ramp package
// Shared widths, constants, types and the white-point factor table.
// ----------------------------------------------------------------------------
package ctgr_pkg;

   localparam int TEMP_W     = 14;
   localparam int INDEX_W    = 12;
   localparam int RS_W       = 13;
   localparam int VALUE_W    = 16;
   localparam int OFF_W      = 13;
   localparam int ROW_W      = 6;
   localparam int FRAC_W     = 7;
   localparam int FACTOR_W   = 17;
   localparam int WEIGHT_W   = 23;
   localparam int CHANNELS   = 3;

   localparam int DEFAULT_MAX_RAMP = 4096;
   localparam int RS_RESET_VALUE   = 256;

   localparam logic [TEMP_W-1:0]  TEMP_LOW  = 14'd3000;
   localparam logic [TEMP_W-1:0]  TEMP_HIGH = 14'd9000;
   localparam logic [FRAC_W-1:0]  TEMP_STEP = 7'd100;
   localparam int                 ROW_COUNT = 61;
   localparam logic [ROW_W-1:0]   LAST_ROW  = 6'd60;
   localparam logic [VALUE_W-1:0] FULL_SCALE = 16'hFFFF;

   // Row number is off / 100, taken as (off * 5243) >> 19; exact for off <= 6000.
   localparam logic [OFF_W-1:0] ROW_RECIP = 13'd5243;
   localparam int               ROW_SHIFT = 19;

   // Final /100 as (t * 10737419) >> 30; exact for t below 6553600.
   localparam logic [23:0] DIV100_RECIP = 24'd10737419;
   localparam int          DIV100_SHIFT = 30;

   // Base divider: 16 quotient bits, four per pipeline stage.
   localparam int DIV_STEPS          = VALUE_W;
   localparam int DIV_STEPS_PER_STAGE = 4;
   localparam int DIV_STAGES         = DIV_STEPS / DIV_STEPS_PER_STAGE;

   // Input stage, divider stages, then two multiply stages.
   localparam int PIPE_DEPTH = DIV_STAGES + 3;

   typedef logic [TEMP_W-1:0]   temp_type;
   typedef logic [INDEX_W-1:0]  index_type;
   typedef logic [RS_W-1:0]     rs_type;
   typedef logic [VALUE_W-1:0]  value_type;
   typedef logic [FACTOR_W-1:0] factor_type;
   typedef logic [WEIGHT_W-1:0] weight_type;
   typedef weight_type [CHANNELS-1:0] weight_vec_type;
   typedef value_type  [CHANNELS-1:0] value_vec_type;

   // White-point factors in unsigned Q1.16: red, green, blue, one row per 100 K.
   localparam factor_type WP_TABLE [ROW_COUNT][CHANNELS] = '{
      '{65536, 47171, 28089}, '{65536, 48031, 29732}, '{65536, 48852, 31322},
      '{65536, 49637, 32863}, '{65536, 50390, 34359}, '{65536, 51110, 35810},
      '{65536, 51801, 37220}, '{65536, 52464, 38590}, '{65536, 53100, 39923},
      '{65536, 53712, 41218}, '{65536, 54300, 42478}, '{65536, 54865, 43704},
      '{65536, 55410, 44898}, '{65536, 55934, 46060}, '{65536, 56438, 47191},
      '{65536, 56925, 48293}, '{65536, 57394, 49366}, '{65536, 57847, 50411},
      '{65536, 58284, 51430}, '{65536, 58705, 52422}, '{65536, 59112, 53389},
      '{65536, 59614, 54289}, '{65536, 60104, 55175}, '{65536, 60583, 56049},
      '{65536, 61051, 56909}, '{65536, 61508, 57757}, '{65536, 61955, 58592},
      '{65536, 62391, 59414}, '{65536, 62818, 60224}, '{65536, 63234, 61020},
      '{65536, 63640, 61804}, '{65536, 64037, 62576}, '{65536, 64425, 63335},
      '{65536, 64804, 64081}, '{65536, 65174, 64815}, '{65536, 65536, 65536},
      '{64846, 65109, 65536}, '{64186, 64699, 65536}, '{63554, 64304, 65536},
      '{62947, 63925, 65536}, '{62365, 63559, 65536}, '{61803, 63205, 65536},
      '{61263, 62864, 65536}, '{60745, 62535, 65536}, '{60246, 62218, 65536},
      '{59765, 61912, 65536}, '{59303, 61616, 65536}, '{58857, 61330, 65536},
      '{58426, 61054, 65536}, '{58011, 60786, 65536}, '{57610, 60527, 65536},
      '{57223, 60277, 65536}, '{56849, 60034, 65536}, '{56487, 59798, 65536},
      '{56136, 59570, 65536}, '{55797, 59349, 65536}, '{55469, 59134, 65536},
      '{55151, 58925, 65536}, '{54842, 58723, 65536}, '{54543, 58526, 65536},
      '{54253, 58335, 65536}
   };

endpackage

/* hw/rtl/ctgr_divider.sv */
// ----------------------------------------------------------------------------
// Base value divider
// Pipelined restoring division giving entry_index * 65536 / ramp_size,
// four quotient bits per stage, saturating when the index is past the ramp.
// ----------------------------------------------------------------------------
module ctgr_divider import ctgr_pkg::*; (
   input  logic      clock,
   input  logic      en,
   input  index_type entry_index,
   input  rs_type    ramp_size,
   output value_type base
);

   rs_type    rem_ff [DIV_STAGES+1];
   value_type quo_ff [DIV_STAGES+1];
   logic      sat_ff [DIV_STAGES+1];

   // Entry stage: the remainder starts as the index, which is below the divisor unless the saturate flag is set.
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= RS_W'(entry_index);
         quo_ff[0] <= '0;
         sat_ff[0] <= (RS_W'(entry_index) >= ramp_size);
      end
   end

   for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_stage
      rs_type    rem_in;
      value_type quo_in;

      always_comb begin : p_steps
         logic [RS_W:0] dbl;
         rem_in = rem_ff[k-1];
         quo_in = quo_ff[k-1];
         for (int s = 0; s < DIV_STEPS_PER_STAGE; s++) begin
            dbl = {rem_in, 1'b0};
            if (dbl >= {1'b0, ramp_size}) begin
               rem_in = RS_W'(dbl - {1'b0, ramp_size});
               quo_in = {quo_in[VALUE_W-2:0], 1'b1};
            end else begin
               rem_in = dbl[RS_W-1:0];
               quo_in = {quo_in[VALUE_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            quo_ff[k] <= quo_in;
            sat_ff[k] <= sat_ff[k-1];
         end
      end
   end

   assign base = sat_ff[DIV_STAGES] ? FULL_SCALE : quo_ff[DIV_STAGES];

endmodule

/* hw/rtl/ctgr_interp.sv */
// ----------------------------------------------------------------------------
// White-point interpolation
// Finds the table row and fraction of the temperature and blends the two
// neighbouring rows into a per-channel weight in Q1.16 scaled by 100.
// ----------------------------------------------------------------------------
module ctgr_interp import ctgr_pkg::*; (
   input  logic           clock,
   input  logic           en,
   input  temp_type       temperature,
   output weight_vec_type weight
);

   logic [OFF_W-1:0]  off_in,  off_ff;
   logic [ROW_W-1:0]  row_in,  row_ff;
   logic [FRAC_W-1:0] frac_in, frac_ff;
   logic [ROW_W-1:0]  next_row;
   factor_type        f_row_in  [CHANNELS];
   factor_type        f_next_in [CHANNELS];
   factor_type        f_row_ff  [CHANNELS];
   factor_type        f_next_ff [CHANNELS];
   weight_vec_type    w_in, w_ff, w_d1_ff, w_d2_ff;

   // Stage one: clamp, offset and row estimate.
   always_comb begin : p_row
      temp_type          tc;
      logic [2*OFF_W-1:0] prod;
      if (temperature < TEMP_LOW) begin
         tc = TEMP_LOW;
      end else if (temperature > TEMP_HIGH) begin
         tc = TEMP_HIGH;
      end else begin
         tc = temperature;
      end
      off_in = OFF_W'(tc - TEMP_LOW);
      prod   = (2*OFF_W)'(off_in) * (2*OFF_W)'(ROW_RECIP);
      row_in = prod[ROW_SHIFT+ROW_W-1:ROW_SHIFT];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         off_ff <= off_in;
         row_ff <= row_in;
      end
   end

   // Stage two: fraction within the row and table lookups.
   always_comb begin : p_lookup
      logic [OFF_W-1:0] rowoff;
      rowoff   = OFF_W'(row_ff) * OFF_W'(TEMP_STEP);
      frac_in  = FRAC_W'(off_ff - rowoff);
      next_row = (row_ff == LAST_ROW) ? row_ff : ROW_W'(row_ff + 1'b1);
      for (int c = 0; c < CHANNELS; c++) begin
         f_row_in[c]  = WP_TABLE[row_ff][c];
         f_next_in[c] = WP_TABLE[next_row][c];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         frac_ff   <= frac_in;
         f_row_ff  <= f_row_in;
         f_next_ff <= f_next_in;
      end
   end

   // Stage three: linear blend of the two rows.
   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         w_in[c] = WEIGHT_W'(f_row_ff[c]) * WEIGHT_W'(TEMP_STEP - frac_ff)
                 + WEIGHT_W'(f_next_ff[c]) * WEIGHT_W'(frac_ff);
      end
   end

   // The two delay stages line the weight up with the divider result.
   always_ff @(posedge clock) begin
      if (en) begin
         w_ff    <= w_in;
         w_d1_ff <= w_ff;
         w_d2_ff <= w_d1_ff;
      end
   end

   assign weight = w_d2_ff;

endmodule

/* hw/rtl/ctgr_scale.sv */
// ----------------------------------------------------------------------------
// Ramp value scaling
// Multiplies the base value by each channel weight and divides by 100 * 65536
// over two register stages.
// ----------------------------------------------------------------------------
module ctgr_scale import ctgr_pkg::*; (
   input  logic           clock,
   input  logic           en,
   input  value_type      base,
   input  weight_vec_type weight,
   output value_vec_type  value
);

   localparam int PROD_W  = VALUE_W + WEIGHT_W;
   localparam int RECIP_W = WEIGHT_W + 24;

   weight_vec_type t_in, t_ff;
   value_vec_type  v_in, v_ff;

   // Dropping the low 16 bits first leaves only the division by 100.
   always_comb begin : p_mul
      logic [PROD_W-1:0] prod;
      for (int c = 0; c < CHANNELS; c++) begin
         prod    = PROD_W'(base) * PROD_W'(weight[c]);
         t_in[c] = prod[PROD_W-1:VALUE_W];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff <= t_in;
      end
   end

   always_comb begin : p_div100
      logic [RECIP_W-1:0] prod;
      for (int c = 0; c < CHANNELS; c++) begin
         prod    = RECIP_W'(t_ff[c]) * RECIP_W'(DIV100_RECIP);
         v_in[c] = prod[DIV100_SHIFT+VALUE_W-1:DIV100_SHIFT];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v_ff <= v_in;
      end
   end

   assign value = v_ff;

endmodule

/* hw/rtl/color_temperature_gamma_ramp.sv */
// ----------------------------------------------------------------------------
// Colour temperature gamma ramp
// Gives the red, green and blue gamma ramp values of one ramp entry for a
// colour temperature, blending a white-point table between 100 K rows.
// ----------------------------------------------------------------------------
// Usage:
//   A request on req_ carries a temperature in kelvin (clamped to 3000..9000)
//   and a ramp entry index. Each request gives exactly one response on rsp_
//   with the three 16-bit ramp values, in request order.
//   The ramp size is written through csr_ (always ready); the user must write
//   it only while no request is in flight, which the block does not enforce.
//   Zero is taken as one and sizes above MAX_RAMP_ENTRIES are limited to it.
//   Reset leaves a ramp size of 256 (or MAX_RAMP_ENTRIES if smaller) and an
//   empty pipeline. One request is accepted in every cycle unless req_stall
//   is high; the depth is set by the base divider, which resolves four quotient
//   bits per stage over four stages, and the two multiply stages behind it.
//   When rsp_stall holds a waiting response, the whole pipeline freezes and
//   req_stall rises in the same cycle; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module color_temperature_gamma_ramp import ctgr_pkg::*; #(
   parameter int MAX_RAMP_ENTRIES = DEFAULT_MAX_RAMP
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_stall,
   input  temp_type  req_temperature,
   input  index_type req_entry_index,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output value_type rsp_red_value,
   output value_type rsp_green_value,
   output value_type rsp_blue_value,
   input  logic      csr_valid,
   output logic      csr_ready,
   input  rs_type    csr_ramp_size
);

   localparam logic [16:0] MAX_RS = 17'(MAX_RAMP_ENTRIES);
   localparam rs_type RS_RESET = (MAX_RAMP_ENTRIES < RS_RESET_VALUE) ?
                                 RS_W'(MAX_RAMP_ENTRIES) : RS_W'(RS_RESET_VALUE);

   rs_type                  rs_in, rs_ff;
   logic [PIPE_DEPTH-1:0]   valid_in, valid_ff;
   logic                    en;
   value_type               base;
   weight_vec_type          weight;
   value_vec_type           value;

   assign csr_ready = 1'b1;

   always_comb begin
      rs_in = rs_ff;
      if (csr_valid && csr_ready) begin
         if (csr_ramp_size == '0) begin
            rs_in = RS_W'(1);
         end else if (17'(csr_ramp_size) > MAX_RS) begin
            rs_in = MAX_RS[RS_W-1:0];
         end else begin
            rs_in = csr_ramp_size;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rs_ff <= RS_RESET;
      end else begin
         rs_ff <= rs_in;
      end
   end

   // The pipeline moves as one unless the response register is held.
   assign en        = !(valid_ff[PIPE_DEPTH-1] && rsp_stall);
   assign req_stall = !en;

   always_comb begin
      valid_in = valid_ff;
      if (en) begin
         valid_in = {valid_ff[PIPE_DEPTH-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   ctgr_divider u_divider (
      .clock       (clock),
      .en          (en),
      .entry_index (req_entry_index),
      .ramp_size   (rs_ff),
      .base        (base)
   );

   ctgr_interp u_interp (
      .clock       (clock),
      .en          (en),
      .temperature (req_temperature),
      .weight      (weight)
   );

   ctgr_scale u_scale (
      .clock  (clock),
      .en     (en),
      .base   (base),
      .weight (weight),
      .value  (value)
   );

   assign rsp_valid       = valid_ff[PIPE_DEPTH-1];
   assign rsp_red_value   = value[0];
   assign rsp_green_value = value[1];
   assign rsp_blue_value  = value[2];

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a held response");

   a_rs_range: assert property (@(posedge clock) disable iff (reset)
      (rs_ff != '0) && (17'(rs_ff) <= MAX_RS))
      else $error("effective ramp size out of range");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !en |=> (valid_ff == $past(valid_ff)))
      else $error("pipeline valid bits moved while frozen");

endmodule

/* verif/color_temperature_gamma_ramp_tb.sv */
// ----------------------------------------------------------------------------
// Colour temperature gamma ramp testbench
// Drives requests through the ramp generator under random idling and output
// stalls across several ramp sizes, predicts each entry's red, green and blue
// values from a white-point table of its own, and checks every response in
// order.
// ----------------------------------------------------------------------------
module color_temperature_gamma_ramp_tb import ctgr_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_HIGH     = 4;
   localparam int CLK_LOW      = 4;
   localparam int RAMP_LIMIT   = 4096;
   localparam int DRAIN_CYCLES = 12;
   localparam int PHASE_ITEMS  = 50;

   localparam int unsigned K_LOW   = 3000;
   localparam int unsigned K_HIGH  = 9000;
   localparam int unsigned K_STEP  = 100;
   localparam int unsigned TOP_ROW = 60;
   localparam int unsigned SAT     = 65535;

   // White-point factors, Q1.16, red/green/blue for each 100 K row from 3000 K.
   localparam int unsigned WHITE_POINT [61][3] = '{
      '{65536, 47171, 28089}, '{65536, 48031, 29732}, '{65536, 48852, 31322},
      '{65536, 49637, 32863}, '{65536, 50390, 34359}, '{65536, 51110, 35810},
      '{65536, 51801, 37220}, '{65536, 52464, 38590}, '{65536, 53100, 39923},
      '{65536, 53712, 41218}, '{65536, 54300, 42478}, '{65536, 54865, 43704},
      '{65536, 55410, 44898}, '{65536, 55934, 46060}, '{65536, 56438, 47191},
      '{65536, 56925, 48293}, '{65536, 57394, 49366}, '{65536, 57847, 50411},
      '{65536, 58284, 51430}, '{65536, 58705, 52422}, '{65536, 59112, 53389},
      '{65536, 59614, 54289}, '{65536, 60104, 55175}, '{65536, 60583, 56049},
      '{65536, 61051, 56909}, '{65536, 61508, 57757}, '{65536, 61955, 58592},
      '{65536, 62391, 59414}, '{65536, 62818, 60224}, '{65536, 63234, 61020},
      '{65536, 63640, 61804}, '{65536, 64037, 62576}, '{65536, 64425, 63335},
      '{65536, 64804, 64081}, '{65536, 65174, 64815}, '{65536, 65536, 65536},
      '{64846, 65109, 65536}, '{64186, 64699, 65536}, '{63554, 64304, 65536},
      '{62947, 63925, 65536}, '{62365, 63559, 65536}, '{61803, 63205, 65536},
      '{61263, 62864, 65536}, '{60745, 62535, 65536}, '{60246, 62218, 65536},
      '{59765, 61912, 65536}, '{59303, 61616, 65536}, '{58857, 61330, 65536},
      '{58426, 61054, 65536}, '{58011, 60786, 65536}, '{57610, 60527, 65536},
      '{57223, 60277, 65536}, '{56849, 60034, 65536}, '{56487, 59798, 65536},
      '{56136, 59570, 65536}, '{55797, 59349, 65536}, '{55469, 59134, 65536},
      '{55151, 58925, 65536}, '{54842, 58723, 65536}, '{54543, 58526, 65536},
      '{54253, 58335, 65536}
   };

   typedef struct {
      temp_type  temperature;
      index_type entry_index;
   } ramp_request_type;

   typedef struct {
      value_type red;
      value_type green;
      value_type blue;
   } ramp_rgb_type;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_stall;
   temp_type  req_temperature = '0;
   index_type req_entry_index = '0;
   logic      rsp_valid;
   logic      rsp_stall = 1'b0;
   value_type rsp_red_value;
   value_type rsp_green_value;
   value_type rsp_blue_value;
   logic      csr_valid = 1'b0;
   logic      csr_ready;
   rs_type    csr_ramp_size = '0;

   ramp_request_type request_backlog [$];
   ramp_rgb_type     ramp_values_due [$];
   rs_type           ramp_size_reg = rs_type'(RS_RESET_VALUE);
   int               requests_issued = 0;
   int               responses_checked = 0;
   int               fail_count = 0;
   int               send_gap = 0;
   int               stall_left = 0;
   bit               steady_flow = 1'b0;

   color_temperature_gamma_ramp #(
      .MAX_RAMP_ENTRIES(RAMP_LIMIT)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_temperature(req_temperature),
      .req_entry_index(req_entry_index),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_red_value  (rsp_red_value),
      .rsp_green_value(rsp_green_value),
      .rsp_blue_value (rsp_blue_value),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_ramp_size  (csr_ramp_size)
   );

   always begin
      #CLK_HIGH;
      clock = 1'b1;
      #CLK_LOW;
      clock = 1'b0;
   end

   function automatic int unsigned effective_size(input rs_type size);
      int unsigned n;
      n = size;
      if (n == 0) n = 1;
      if (n > RAMP_LIMIT) n = RAMP_LIMIT;
      return n;
   endfunction

   function automatic ramp_rgb_type ramp_entry_value(input temp_type kelvin,
                                                     input index_type idx,
                                                     input rs_type size);
      int unsigned     t, off, row, nxt, frac, entries, base;
      longint unsigned weight, scaled;
      value_type       chan [3];
      ramp_rgb_type    rgb;
      t = kelvin;
      if (t < K_LOW) t = K_LOW;
      if (t > K_HIGH) t = K_HIGH;
      off  = t - K_LOW;
      row  = off / K_STEP;
      frac = off % K_STEP;
      nxt  = (row < TOP_ROW) ? row + 1 : row;
      entries = effective_size(size);
      base = (idx >= entries) ? SAT : (int'(idx) * 65536) / entries;
      for (int ch = 0; ch < 3; ch++) begin
         weight = longint'(WHITE_POINT[row][ch]) * (K_STEP - frac)
                + longint'(WHITE_POINT[nxt][ch]) * frac;
         scaled = (longint'(base) * weight) / (longint'(K_STEP) * 65536);
         if (scaled > SAT) scaled = SAT;
         chan[ch] = value_type'(scaled);
      end
      rgb.red   = chan[0];
      rgb.green = chan[1];
      rgb.blue  = chan[2];
      return rgb;
   endfunction

   // Request driver: the expectation is formed at the edge the request is taken.
   always @(posedge clock) begin
      ramp_request_type next_req;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall)
            ramp_values_due.push_back(ramp_entry_value(req_temperature, req_entry_index,
                                                       ramp_size_reg));
         if (!(req_valid && req_stall)) begin
            if (send_gap != 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (request_backlog.size() != 0) begin
               next_req = request_backlog.pop_front();
               req_valid       <= 1'b1;
               req_temperature <= next_req.temperature;
               req_entry_index <= next_req.entry_index;
               if (!steady_flow && $urandom_range(0, 5) == 0)
                  send_gap = $urandom_range(1, 10);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Register shadow.
   always @(posedge clock) begin
      if (reset)
         ramp_size_reg <= rs_type'(RS_RESET_VALUE);
      else if (csr_valid && csr_ready)
         ramp_size_reg <= csr_ramp_size;
   end

   // Response monitor and back-pressure.
   always @(posedge clock) begin
      ramp_rgb_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (ramp_values_due.size() == 0) begin
               $error("response with no request outstanding: r=%0d g=%0d b=%0d",
                      rsp_red_value, rsp_green_value, rsp_blue_value);
               fail_count++;
            end else begin
               want = ramp_values_due.pop_front();
               responses_checked++;
               if (rsp_red_value !== want.red) begin
                  $error("red_value: expected %0d, got %0d", want.red, rsp_red_value);
                  fail_count++;
               end
               if (rsp_green_value !== want.green) begin
                  $error("green_value: expected %0d, got %0d", want.green, rsp_green_value);
                  fail_count++;
               end
               if (rsp_blue_value !== want.blue) begin
                  $error("blue_value: expected %0d, got %0d", want.blue, rsp_blue_value);
                  fail_count++;
               end
            end
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!steady_flow && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 9);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic add_request(input int unsigned kelvin, input int unsigned idx);
      ramp_request_type r;
      r.temperature = temp_type'(kelvin);
      r.entry_index = index_type'(idx);
      request_backlog.push_back(r);
      requests_issued++;
   endtask

   task automatic add_random_requests(input int count);
      int unsigned entries, kelvin, idx;
      entries = effective_size(ramp_size_reg);
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(0, 9))
            0: kelvin = $urandom_range(0, 16383);
            1: begin
               case ($urandom_range(0, 3))
                  0: kelvin = K_LOW;
                  1: kelvin = K_HIGH;
                  2: kelvin = K_LOW - 1;
                  default: kelvin = K_HIGH + 1;
               endcase
            end
            default: kelvin = $urandom_range(K_LOW, K_HIGH);
         endcase
         case ($urandom_range(0, 7))
            0, 1: idx = $urandom_range(0, 4095);
            2: begin
               // Around the ramp size, where the base value starts to saturate.
               idx = entries - 1 + $urandom_range(0, 2);
               if (idx > 4095) idx = 4095;
            end
            default: idx = $urandom_range(0, entries - 1);
         endcase
         add_request(kelvin, idx);
      end
   endtask

   task automatic write_ramp_size(input rs_type size);
      csr_valid     <= 1'b1;
      csr_ramp_size <= size;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (responses_checked != requests_issued);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      rs_type ramp_sizes [$];
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed requests at the reset ramp size of 256.
      add_request(3000, 0);
      add_request(9000, 255);
      add_request(0, 100);
      add_request(16383, 4095);
      add_request(2999, 200);
      add_request(9001, 17);
      add_request(3050, 128);
      add_request(3099, 64);
      add_request(3100, 1);
      add_request(8999, 254);
      add_request(8900, 256);
      add_request(6500, 255);
      add_request(5555, 257);
      add_request(14'h2AAA, 12'hAAA);
      add_request(14'h1555, 12'h555);
      add_request(4321, 12'h0AA);
      add_request(7777, 12'h055);
      add_request(3000, 4095);
      add_request(9000, 0);
      wait_drained();

      ramp_sizes = '{13'd1, 13'd4096, 13'd0, 13'd8191, 13'd4097, 13'd255, 13'd2,
                     13'd100};
      ramp_sizes.push_back(rs_type'($urandom_range(1, 4096)));
      ramp_sizes.push_back(rs_type'($urandom_range(0, 8191)));
      foreach (ramp_sizes[p]) begin
         write_ramp_size(ramp_sizes[p]);
         add_random_requests(PHASE_ITEMS);
         wait_drained();
      end

      // Closing stretch at full rate with no idling on either side.
      steady_flow = 1'b1;
      write_ramp_size(13'd256);
      add_random_requests(PHASE_ITEMS);
      wait_drained();

      if (ramp_values_due.size() != 0) begin
         $error("%0d responses never arrived", ramp_values_due.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("** color_temperature_gamma_ramp: PASSED **");
      else
         $display("** color_temperature_gamma_ramp: FAILED **");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("** color_temperature_gamma_ramp: FAILED **");
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/ctgr_pkg.sv
hw/rtl/ctgr_divider.sv
hw/rtl/ctgr_interp.sv
hw/rtl/ctgr_scale.sv
hw/rtl/color_temperature_gamma_ramp.sv
verif/color_temperature_gamma_ramp_tb.sv
